// ===== design/slj_pkg.sv =====
package slj_pkg;

  localparam int MAX_LINES  = 64;
  localparam int INDEX_BITS = 20;
  localparam int LINE_BITS  = $clog2(MAX_LINES);

  localparam int RANGE_W    = 24;
  localparam int ELEV_W     = 16;
  localparam int ORIGIN_W   = 16;
  localparam int INV_W      = 24;
  localparam int THR_W      = 23;
  localparam int CNT_W      = 7;
  localparam int FRAC_SHIFT = 25;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LINE_ORIGIN   = 2'd0,
    CFG_INV_ANGLE_RES = 2'd1,
    CFG_JUMP_THR      = 2'd2,
    CFG_LINE_COUNT    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ORIGIN_W-1:0] line_origin;
    logic [INV_W-1:0]    inv_angle_res;
    logic [THR_W-1:0]    jump_threshold;
    logic [CNT_W-1:0]    line_count;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0]    range;
    logic [INDEX_BITS-1:0] index;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/slj_ram.sv =====
module slj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/slj_line_map.sv =====
module slj_line_map import slj_pkg::*; (
  input  logic [ELEV_W-1:0]    elevation_i,
  input  cfg_t                 cfg_i,
  output logic [LINE_BITS-1:0] line_o
);

  localparam int DIFF_W   = ELEV_W + 1;
  localparam int PROD_W   = DIFF_W + INV_W + 1;
  localparam int QW       = PROD_W - FRAC_SHIFT;
  localparam int CNT_NEED = $clog2(MAX_LINES + 1);
  localparam int NW       = (CNT_W > CNT_NEED) ? CNT_W : CNT_NEED;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [QW-1:0]     q;
  logic signed [QW-1:0]     n_s;
  logic [NW-1:0]            n_raw;
  logic [NW-1:0]            n;
  logic [NW-1:0]            n_last;

  assign diff = $signed({elevation_i[ELEV_W-1], elevation_i})
              - $signed({{(DIFF_W-ORIGIN_W){cfg_i.line_origin[ORIGIN_W-1]}},
                         cfg_i.line_origin});
  assign prod = PROD_W'(diff) * $signed({1'b0, cfg_i.inv_angle_res});
  // arithmetic shift of the Q.25 product is the floor
  assign q    = prod[PROD_W-1:FRAC_SHIFT];

  assign n_raw = NW'(cfg_i.line_count);

  always_comb begin
    if (n_raw == '0) begin
      n = NW'(1);
    end else if (n_raw > NW'(MAX_LINES)) begin
      n = NW'(MAX_LINES);
    end else begin
      n = n_raw;
    end
  end

  assign n_s    = $signed(QW'(n));
  assign n_last = n - NW'(1);

  always_comb begin
    if (q < 0) begin
      line_o = '0;
    end else if (q >= n_s) begin
      line_o = n_last[LINE_BITS-1:0];
    end else begin
      line_o = q[LINE_BITS-1:0];
    end
  end

endmodule

// ===== design/scan_line_jump_outlier_unit.sv =====
// Range jump outlier detector for lidar points, one point per scan line store
// access. A point is accepted in every cycle when the output side keeps up,
// and each point then moves through the stages in order: the input register
// feeds the elevation multiply and line clamp, which address the line store
// RAM (registered read); the range compare follows and lands in the result
// register. Back-to-back points on the same line are forwarded around the
// RAM. new_pass clears per-line valid flags in the same cycle, so no clearing
// pass is needed after reset or between passes. Configuration must be written
// only while no transaction is in flight.
module scan_line_jump_outlier_unit import slj_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  new_pass_i,
  input  logic                  point_valid_i,
  input  logic [RANGE_W-1:0]    range_value_i,
  input  logic [ELEV_W-1:0]     elevation_i,
  input  logic [INDEX_BITS-1:0] point_index_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  reject_current_o,
  output logic                  reject_earlier_o,
  output logic [INDEX_BITS-1:0] earlier_index_o,
  output logic [LINE_BITS-1:0]  line_number_o
);

  localparam int DW = RANGE_W + 1;

  cfg_t cfg_q;

  // stage A: input register
  logic                  a_vld_q;
  logic                  a_new_pass_q;
  logic                  a_point_q;
  logic [RANGE_W-1:0]    a_range_q;
  logic [ELEV_W-1:0]     a_elev_q;
  logic [INDEX_BITS-1:0] a_index_q;
  logic [LINE_BITS-1:0]  a_line;

  // stage B: store read data available
  logic                  b_vld_q;
  logic                  b_new_pass_q;
  logic                  b_point_q;
  logic [RANGE_W-1:0]    b_range_q;
  logic [INDEX_BITS-1:0] b_index_q;
  logic [LINE_BITS-1:0]  b_line_q;
  logic [ENTRY_W-1:0]    rdata;

  // result register
  logic                  out_vld_q;
  logic                  rej_q;
  logic [INDEX_BITS-1:0] earlier_q;
  logic [LINE_BITS-1:0]  line_q;

  // last write, for same-line points in consecutive slots
  logic                  fwd_en_q;
  logic [LINE_BITS-1:0]  fwd_line_q;
  entry_t                fwd_q;

  logic [MAX_LINES-1:0]  vld_q;
  logic [MAX_LINES-1:0]  vld_d;

  logic                  out_ready;
  logic                  b_adv;
  logic                  b_ready;
  logic                  a_adv;
  logic                  a_ready;
  logic                  in_acc;

  entry_t                prev;
  entry_t                wr_entry;
  logic signed [DW-1:0]  diff;
  logic [DW-1:0]         mag;
  logic                  jump;
  logic                  wr_en;

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign b_adv      = b_vld_q && out_ready;
  assign b_ready    = !b_vld_q || b_adv;
  assign a_adv      = a_vld_q && b_ready;
  assign a_ready    = !a_vld_q || a_adv;
  assign in_stall_o = !a_ready;
  assign in_acc     = in_valid_i && a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_origin    <= '0;
      cfg_q.inv_angle_res  <= INV_W'(4096);
      cfg_q.jump_threshold <= THR_W'(197);
      cfg_q.line_count     <= CNT_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_LINE_ORIGIN:   cfg_q.line_origin    <= cfg_data_i[ORIGIN_W-1:0];
        CFG_INV_ANGLE_RES: cfg_q.inv_angle_res  <= cfg_data_i[INV_W-1:0];
        CFG_JUMP_THR:      cfg_q.jump_threshold <= cfg_data_i[THR_W-1:0];
        CFG_LINE_COUNT:    cfg_q.line_count     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  slj_line_map u_line_map (
    .elevation_i (a_elev_q),
    .cfg_i       (cfg_q),
    .line_o      (a_line)
  );

  slj_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LINES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (b_line_q),
    .wdata_i (wr_entry),
    .re_i    (a_adv),
    .raddr_i (a_line),
    .rdata_o (rdata)
  );

  always_comb begin
    if (b_new_pass_q) begin
      prev = '0;
    end else if (fwd_en_q && (fwd_line_q == b_line_q)) begin
      prev = fwd_q;
    end else if (vld_q[b_line_q]) begin
      prev = entry_t'(rdata);
    end else begin
      prev = '0;
    end
  end

  assign diff = $signed({b_range_q[RANGE_W-1], b_range_q})
              - $signed({prev.range[RANGE_W-1], prev.range});
  assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign jump = b_point_q && (mag > DW'(cfg_q.jump_threshold));

  assign wr_en          = b_adv && b_point_q;
  assign wr_entry.range = b_range_q;
  assign wr_entry.index = b_index_q;

  always_comb begin
    vld_d = vld_q;
    if (b_adv) begin
      if (b_new_pass_q) begin
        vld_d = '0;
      end
      if (b_point_q) begin
        vld_d[b_line_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_en_q  <= 1'b0;
      vld_q     <= '0;
    end else begin
      vld_q <= vld_d;
      if (a_ready) begin
        a_vld_q <= in_valid_i;
      end
      if (b_ready) begin
        b_vld_q <= a_vld_q;
      end
      if (b_adv) begin
        out_vld_q <= 1'b1;
        fwd_en_q  <= b_point_q;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_new_pass_q <= new_pass_i;
      a_point_q    <= point_valid_i;
      a_range_q    <= range_value_i;
      a_elev_q     <= elevation_i;
      a_index_q    <= point_index_i;
    end
    if (a_adv) begin
      b_new_pass_q <= a_new_pass_q;
      b_point_q    <= a_point_q;
      b_range_q    <= a_range_q;
      b_index_q    <= a_index_q;
      b_line_q     <= a_line;
    end
    if (b_adv) begin
      rej_q      <= jump;
      earlier_q  <= jump ? prev.index : '0;
      line_q     <= b_line_q;
      fwd_line_q <= b_line_q;
      fwd_q      <= wr_entry;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign reject_current_o = rej_q;
  assign reject_earlier_o = rej_q;
  assign earlier_index_o  = earlier_q;
  assign line_number_o    = line_q;

endmodule

// ===== verif/tb_scan_line_jump_outlier_unit.sv =====
module tb_scan_line_jump_outlier_unit;
  import slj_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                  reject_current;
    logic                  reject_earlier;
    logic [INDEX_BITS-1:0] earlier_index;
    logic [LINE_BITS-1:0]  line_number;
  } verdict_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  new_pass_i;
  logic                  point_valid_i;
  logic [RANGE_W-1:0]    range_value_i;
  logic [ELEV_W-1:0]     elevation_i;
  logic [INDEX_BITS-1:0] point_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  reject_current_o;
  logic                  reject_earlier_o;
  logic [INDEX_BITS-1:0] earlier_index_o;
  logic [LINE_BITS-1:0]  line_number_o;

  scan_line_jump_outlier_unit u_top (.*);

  // line store shadow and register copies
  logic signed [ORIGIN_W-1:0] line_origin_q = '0;
  logic [INV_W-1:0]           inv_res_q     = 24'd4096;
  logic [THR_W-1:0]           jump_thr_q    = 23'd197;
  logic [CNT_W-1:0]           line_count_q  = 7'd32;
  logic signed [RANGE_W-1:0]  last_range [MAX_LINES] = '{default: '0};
  logic [INDEX_BITS-1:0]      last_index [MAX_LINES] = '{default: '0};

  verdict_t pending_verdicts[$];
  int       fault_count;
  int       cycle_count;
  int       sender_idle_pct;
  int       receiver_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  function automatic logic [LINE_BITS-1:0] line_of(logic signed [ELEV_W-1:0] elev);
    longint prod;
    longint q;
    longint lines;
    prod  = (longint'(elev) - longint'(line_origin_q)) * longint'(inv_res_q);
    q     = prod >>> FRAC_SHIFT;
    lines = longint'(line_count_q);
    if (lines == 0) lines = 1;
    if (lines > MAX_LINES) lines = MAX_LINES;
    if (q < 0) return '0;
    if (q >= lines) return LINE_BITS'(lines - 1);
    return LINE_BITS'(q);
  endfunction

  function automatic verdict_t score_point(logic np, logic pv,
                                           logic signed [RANGE_W-1:0] rng,
                                           logic signed [ELEV_W-1:0] elev,
                                           logic [INDEX_BITS-1:0] idx);
    verdict_t               v;
    logic [LINE_BITS-1:0]   ln;
    longint                 gap;
    if (np) begin
      foreach (last_range[k]) begin
        last_range[k] = '0;
        last_index[k] = '0;
      end
    end
    ln = line_of(elev);
    v = '0;
    v.line_number = ln;
    if (pv) begin
      gap = longint'(rng) - longint'(last_range[ln]);
      if (gap < 0) gap = -gap;
      if (gap > longint'(jump_thr_q)) begin
        v.reject_current = 1'b1;
        v.reject_earlier = 1'b1;
        v.earlier_index  = last_index[ln];
      end
      last_range[ln] = rng;
      last_index[ln] = idx;
    end
    return v;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fault_count = fault_count + 1;
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    verdict_t v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        fault_count = fault_count + 1;
        $display("%0t: unexpected transaction, expected none got line %0h", $time,
                 line_number_o);
      end else begin
        v = pending_verdicts.pop_front();
        check_field("reject_current", 32'(v.reject_current), 32'(reject_current_o));
        check_field("reject_earlier", 32'(v.reject_earlier), 32'(reject_earlier_o));
        check_field("earlier_index", 32'(v.earlier_index), 32'(earlier_index_o));
        check_field("line_number", 32'(v.line_number), 32'(line_number_o));
      end
    end
  end

  task automatic send_point(input logic np, input logic pv, input logic [RANGE_W-1:0] rng,
                            input logic [ELEV_W-1:0] elev,
                            input logic [INDEX_BITS-1:0] idx);
    verdict_t expected;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    new_pass_i    <= np;
    point_valid_i <= pv;
    range_value_i <= rng;
    elevation_i   <= elev;
    point_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    expected         = score_point(np, pv, rng, elev, idx);
    pending_verdicts = {pending_verdicts, expected};
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (sel)
      CFG_LINE_ORIGIN:   line_origin_q = data[ORIGIN_W-1:0];
      CFG_INV_ANGLE_RES: inv_res_q     = data[INV_W-1:0];
      CFG_JUMP_THR:      jump_thr_q    = data[THR_W-1:0];
      CFG_LINE_COUNT:    line_count_q  = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_default_regs();
    send_point(1'b1, 1'b1, 24'd1000, 16'd0, 20'd5);
    send_point(1'b0, 1'b1, 24'd1100, 16'd100, 20'd6);
    send_point(1'b0, 1'b0, 24'h800000, 16'd200, 20'd7);
    send_point(1'b0, 1'b1, 24'd1297, 16'd300, 20'd8);
    send_point(1'b0, 1'b1, 24'd1495, 16'd400, 20'd9);
    send_point(1'b0, 1'b1, 24'h7FFFFF, 16'h7FFF, 20'hFFFFF);
    send_point(1'b0, 1'b1, 24'h800000, 16'h7FFF, 20'd0);
    send_point(1'b0, 1'b1, 24'd50, 16'h8000, 20'd1);
  endtask

  task automatic test_line_clamping();
    wait_for_idle();
    write_reg(CFG_LINE_COUNT, 24'd127);
    write_reg(CFG_INV_ANGLE_RES, 24'hFFFFFF);
    write_reg(CFG_LINE_ORIGIN, 24'h008000);
    send_point(1'b0, 1'b1, 24'd0, 16'h8000, 20'd2);
    send_point(1'b0, 1'b1, 24'd0, 16'h8001, 20'd3);
    send_point(1'b0, 1'b1, 24'd0, 16'h8002, 20'd4);
    send_point(1'b0, 1'b1, 24'd0, 16'h7FFF, 20'd10);
    wait_for_idle();
    write_reg(CFG_LINE_COUNT, 24'd0);
    send_point(1'b0, 1'b1, 24'd0, 16'h7FFF, 20'd11);
    wait_for_idle();
    write_reg(CFG_LINE_COUNT, 24'd64);
    write_reg(CFG_LINE_ORIGIN, 24'h007FFF);
    write_reg(CFG_INV_ANGLE_RES, 24'd0);
    send_point(1'b0, 1'b1, 24'd0, 16'h8000, 20'd12);
    wait_for_idle();
    write_reg(CFG_INV_ANGLE_RES, 24'd4096);
    send_point(1'b0, 1'b1, 24'd0, 16'h8000, 20'd13);
  endtask

  task automatic test_jump_threshold();
    wait_for_idle();
    write_reg(CFG_LINE_ORIGIN, 24'd0);
    write_reg(CFG_INV_ANGLE_RES, 24'd32768);
    write_reg(CFG_JUMP_THR, 24'd0);
    send_point(1'b1, 1'b1, 24'd77, 16'd2048, 20'd14);
    send_point(1'b0, 1'b1, 24'd77, 16'd2048, 20'd15);
    send_point(1'b0, 1'b1, 24'd78, 16'd2100, 20'd16);
    wait_for_idle();
    write_reg(CFG_JUMP_THR, 24'h7FFFFF);
    send_point(1'b0, 1'b1, 24'h7FFFFF, 16'd2048, 20'd17);
    send_point(1'b0, 1'b1, 24'h800000, 16'd2048, 20'd18);
  endtask

  task automatic test_new_pass();
    wait_for_idle();
    write_reg(CFG_JUMP_THR, 24'd197);
    send_point(1'b0, 1'b1, 24'd5000, 16'd4096, 20'd19);
    send_point(1'b0, 1'b1, 24'd5010, 16'd4096, 20'd20);
    send_point(1'b1, 1'b1, 24'd5020, 16'd4096, 20'd21);
    send_point(1'b1, 1'b0, 24'd0, 16'd4096, 20'd22);
    send_point(1'b0, 1'b1, 24'd100, 16'd4096, 20'd23);
  endtask

  // Most points follow a few beams with a small range walk around the
  // threshold; the rest are hard jumps or fully random points.
  task automatic test_random_scan(input int idle, input int stall, input int count);
    logic signed [ELEV_W-1:0]  beams [8];
    logic signed [RANGE_W-1:0] walk [8];
    logic signed [RANGE_W-1:0] rng;
    logic signed [ELEV_W-1:0]  elev;
    logic                      np;
    logic                      pv;
    int                        org;
    int                        thr_val;
    int                        b;
    int                        r;
    int                        jump;
    wait_for_idle();
    org     = -int'($urandom_range(16384));
    thr_val = $urandom_range(16, 4096);
    write_reg(CFG_LINE_ORIGIN, {8'($urandom), org[15:0]});
    write_reg(CFG_INV_ANGLE_RES, 24'($urandom_range(16384, 131072)));
    write_reg(CFG_JUMP_THR, {1'($urandom), 23'(thr_val)});
    write_reg(CFG_LINE_COUNT, {17'($urandom), 7'($urandom_range(1, 64))});
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    for (int k = 0; k < 8; k++) begin
      beams[k] = 16'(org + int'($urandom_range(32767)));
      walk[k]  = 24'($urandom_range(4000000));
    end
    for (int n = 0; n < count; n++) begin
      r  = $urandom_range(99);
      b  = $urandom_range(7);
      np = (n == 0) || ($urandom_range(99) < 2);
      pv = ($urandom_range(99) < 88);
      if (r < 75) begin
        elev    = beams[b];
        walk[b] = 24'(walk[b] + (int'($urandom_range(2 * thr_val + 2)) - thr_val - 1));
        rng     = walk[b];
      end else if (r < 90) begin
        elev = beams[b];
        jump = int'($urandom_range(1, 100000)) + thr_val;
        if ($urandom_range(1)) jump = -jump;
        walk[b] = 24'(walk[b] + jump);
        rng     = walk[b];
      end else begin
        elev = 16'($urandom);
        rng  = 24'($urandom);
      end
      send_point(np, pv, rng, elev, 20'($urandom));
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_addr_i         = CFG_LINE_ORIGIN;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    new_pass_i         = 1'b0;
    point_valid_i      = 1'b0;
    range_value_i      = '0;
    elevation_i        = '0;
    point_index_i      = '0;
    out_stall_i        = 1'b0;
    fault_count        = 0;
    cycle_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_regs();
    test_line_clamping();
    test_jump_threshold();
    test_new_pass();
    test_random_scan(0, 0, 110);
    test_random_scan(81, 0, 110);
    test_random_scan(0, 81, 110);
    test_random_scan(33, 33, 110);
    wait_for_idle();
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
